// ===== rtl/core/unix_seconds_to_calendar_core_assert.svh =====
// Assertion macros used by the calendar core checker.
`ifndef UNIX_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define USTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define USTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ustc_pkg.sv =====
// Types, constants and helper functions of the calendar core.
package ustc_pkg;

  localparam int SHIFT_W = 32;
  localparam int REM_W   = 11;
  localparam int CNT_W   = 6;
  localparam int DAY_W   = 16;
  localparam int YDAY_W  = 9;

  localparam logic [REM_W-1:0] DIV_SEC    = 11'd60;
  localparam logic [REM_W-1:0] DIV_MIN    = 11'd60;
  localparam logic [REM_W-1:0] DIV_HOUR   = 11'd24;
  localparam logic [REM_W-1:0] DIV_PERIOD = 11'd1461;

  localparam logic [CNT_W-1:0] NBITS_SEC    = 6'd32;
  localparam logic [CNT_W-1:0] NBITS_MIN    = 6'd27;
  localparam logic [CNT_W-1:0] NBITS_HOUR   = 6'd21;
  localparam logic [CNT_W-1:0] NBITS_PERIOD = 6'd16;

  localparam logic [DAY_W-1:0] DAYS_1968_TO_1970 = 16'd731;
  localparam logic [7:0]       YEAR_OFFSET_1900  = 8'd68;
  localparam logic [2:0]       WEEKDAY_EPOCH     = 3'd4;
  localparam logic [2:0]       DAYS_PER_WEEK     = 3'd7;

  localparam logic [REM_W-1:0] YEAR1_START = 11'd366;
  localparam logic [REM_W-1:0] YEAR2_START = 11'd731;
  localparam logic [REM_W-1:0] YEAR3_START = 11'd1096;

  localparam logic [3:0] MONTH_LAST  = 4'd11;
  localparam logic [3:0] MONTH_MARCH = 4'd2;

  localparam logic [YDAY_W-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_HOUR,
    S_PERIOD,
    S_MONTH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               go;
    logic [SHIFT_W-1:0] dividend;
    logic [REM_W-1:0]   divisor;
    logic [CNT_W-1:0]   nbits;
  } div_cmd_t;

  typedef struct packed {
    logic active;
    logic qbit;
  } div_stat_t;

  function automatic logic [YDAY_W-1:0] month_offset(logic [3:0] m, logic leap);
    logic [YDAY_W-1:0] r;
    r = MONTH_START[m];
    if (leap && (m >= MONTH_MARCH)) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

  function automatic logic [2:0] mod7_step(logic [2:0] acc, logic b);
    logic [3:0] v;
    v = {acc, b};
    if (v >= {1'b0, DAYS_PER_WEEK}) begin
      v = v - {1'b0, DAYS_PER_WEEK};
    end
    return v[2:0];
  endfunction

  function automatic logic [2:0] weekday_of(logic [2:0] acc);
    logic [3:0] s;
    s = {1'b0, acc} + {1'b0, WEEKDAY_EPOCH};
    if (s >= {1'b0, DAYS_PER_WEEK}) begin
      s = s - {1'b0, DAYS_PER_WEEK};
    end
    return s[2:0];
  endfunction

endpackage

// ===== rtl/core/ustc_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ustc_serial_div (
  input  logic                       clk,
  input  logic                       rst,
  input  ustc_pkg::div_cmd_t         cmd,
  output ustc_pkg::div_stat_t        stat,
  output logic [ustc_pkg::SHIFT_W-1:0] quotient,
  output logic [ustc_pkg::REM_W-1:0]   remainder
);
  import ustc_pkg::*;

  logic [SHIFT_W-1:0] shreg;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   div;
  logic [CNT_W-1:0]   cnt;
  logic               active;
  logic [REM_W:0]     trial;
  logic [REM_W:0]     diff;
  logic               ge;

  assign trial = {rem, shreg[SHIFT_W-1]};
  assign diff  = trial - {1'b0, div};
  assign ge    = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (cmd.go) begin
      active <= 1'b1;
      cnt    <= cmd.nbits;
    end else if (active) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      shreg <= cmd.dividend;
      rem   <= '0;
      div   <= cmd.divisor;
    end else if (active) begin
      shreg <= {shreg[SHIFT_W-2:0], ge};
      rem   <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign stat.active = active;
  assign stat.qbit   = ge;
  assign quotient    = shreg;
  assign remainder   = rem;

endmodule

// ===== rtl/core/unix_seconds_to_calendar_core.sv =====
// Calendar core: breaks a 32-bit seconds count into date and time fields.
//
//   channel  | handshake        | words
//   ---------+------------------+----------------------------------------------
//   input    | start, busy      | unix_seconds
//   result   | done (1 cycle)   | second, minute, hour, day_of_year,
//            |                  | day_of_month, month_index, weekday,
//            |                  | years_since_1900
//
// Busy drops the cycle after done.
// One serial divider makes four passes (32, 27, 21 and 16 bits, one bit a cycle),
// then the month search steps back from December, one month a cycle.
// Reset clears the sequencer; result ports hold their last word.
// The receiver cannot stall; done is high for one cycle per word.
module unix_seconds_to_calendar_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [8:0]  day_of_year,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_index,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900
);
  import ustc_pkg::*;

  state_t             state;
  state_t             state_next;
  div_cmd_t           cmd;
  div_stat_t          stat;
  logic [SHIFT_W-1:0] quotient;
  logic [REM_W-1:0]   remainder;

  logic [2:0]         wd_acc;
  logic               leap;
  logic [3:0]         month;
  logic [DAY_W-1:0]   day68;
  logic [1:0]         year_in_period;
  logic [REM_W-1:0]   yday_wide;
  logic [7:0]         y1900_calc;
  logic [YDAY_W-1:0]  start_cur;
  logic [YDAY_W-1:0]  dom_calc;
  logic               month_hit;

  ustc_serial_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign day68 = quotient[DAY_W-1:0] + DAYS_1968_TO_1970;

  always_comb begin
    if (remainder < YEAR1_START) begin
      year_in_period = 2'd0;
      yday_wide      = remainder;
    end else if (remainder < YEAR2_START) begin
      year_in_period = 2'd1;
      yday_wide      = remainder - YEAR1_START;
    end else if (remainder < YEAR3_START) begin
      year_in_period = 2'd2;
      yday_wide      = remainder - YEAR2_START;
    end else begin
      year_in_period = 2'd3;
      yday_wide      = remainder - YEAR3_START;
    end
  end

  assign y1900_calc = {quotient[5:0], 2'b00} + {6'd0, year_in_period} + YEAR_OFFSET_1900;

  assign start_cur = month_offset(month, leap);
  assign dom_calc  = day_of_year - start_cur + 9'd1;
  assign month_hit = (month == 4'd0) || (day_of_year >= start_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.go       = 1'b0;
    cmd.dividend = '0;
    cmd.divisor  = '0;
    cmd.nbits    = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.go       = 1'b1;
          cmd.dividend = unix_seconds;
          cmd.divisor  = DIV_SEC;
          cmd.nbits    = NBITS_SEC;
          state_next   = S_SEC;
        end
      end
      S_SEC: begin
        if (!stat.active) begin
          cmd.go       = 1'b1;
          cmd.dividend = quotient << (SHIFT_W - int'(NBITS_MIN));
          cmd.divisor  = DIV_MIN;
          cmd.nbits    = NBITS_MIN;
          state_next   = S_MIN;
        end
      end
      S_MIN: begin
        if (!stat.active) begin
          cmd.go       = 1'b1;
          cmd.dividend = quotient << (SHIFT_W - int'(NBITS_HOUR));
          cmd.divisor  = DIV_HOUR;
          cmd.nbits    = NBITS_HOUR;
          state_next   = S_HOUR;
        end
      end
      S_HOUR: begin
        if (!stat.active) begin
          cmd.go       = 1'b1;
          cmd.dividend = {day68, {(SHIFT_W-DAY_W){1'b0}}};
          cmd.divisor  = DIV_PERIOD;
          cmd.nbits    = NBITS_PERIOD;
          state_next   = S_PERIOD;
        end
      end
      S_PERIOD: begin
        if (!stat.active) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if (month_hit) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SEC: begin
        if (!stat.active) begin
          second <= remainder[5:0];
        end
      end
      S_MIN: begin
        if (!stat.active) begin
          minute <= remainder[5:0];
          wd_acc <= '0;
        end
      end
      S_HOUR: begin
        if (stat.active) begin
          wd_acc <= mod7_step(wd_acc, stat.qbit);
        end else begin
          hour    <= remainder[4:0];
          weekday <= weekday_of(wd_acc);
        end
      end
      S_PERIOD: begin
        if (!stat.active) begin
          day_of_year      <= yday_wide[YDAY_W-1:0];
          years_since_1900 <= y1900_calc;
          leap             <= (year_in_period == 2'd0);
          month            <= MONTH_LAST;
        end
      end
      S_MONTH: begin
        if (month_hit) begin
          day_of_month <= dom_calc[4:0];
          month_index  <= month;
        end else begin
          month <= month - 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== rtl/core/ustc_checker.sv =====
// Port-level checker for the calendar core, bound to the top level.
`include "unix_seconds_to_calendar_core_assert.svh"

module ustc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [5:0]  second,
  input logic [5:0]  minute,
  input logic [4:0]  hour,
  input logic [8:0]  day_of_year,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_index,
  input logic [2:0]  weekday,
  input logic [7:0]  years_since_1900
);

  `USTC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not raise busy")
  `USTC_ASSERT_NEXT(a_done_ends, done, !done && !busy, "done strobe not followed by idle")
  `USTC_ASSERT_NOW(a_busy_falls, $fell(busy) && !$past(rst), $past(done), "busy fell without done")
  `USTC_ASSERT_NOW(a_fields_range, done, (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) && (month_index < 4'd12) && (weekday < 3'd7) && (day_of_month != 5'd0) && (day_of_year < 9'd366) && (years_since_1900 >= 8'd70), "result field out of range")

endmodule

bind unix_seconds_to_calendar_core ustc_checker u_ustc_checker (.*);
